### sv/psmmd_pkg.sv
// Shared types and constants for the point-set min/max distance block.
package psmmd_pkg;

    localparam int MODE_W  = 2;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 34;
    localparam int DIST_W  = 17;
    localparam int POINT_W = 2 * COORD_W;

    // Square root unit: one result bit per step
    localparam int SQRT_STEPS  = DIST_W;
    localparam int SQRT_CNT_W  = 5;
    localparam int SQRT_REM_W  = DIST_W + 1;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_STORE   = 2'd0;
    localparam mode_t MODE_PROCESS = 2'd1;
    localparam mode_t MODE_FINISH  = 2'd2;

    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;

    localparam sq_t SQ_ALL_ONES = '1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SQMIN = 5'b00100,
        S_SQMAX = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

endpackage

### sv/point_set_min_max_distance.sv
// Top level: smallest and largest distance between two stored/streamed 2-D point sets.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, x_coord, y_coord.
//   mode store   : write the point into the point memory; points past
//                  MAX_POINTS are dropped and raise the overflow flag.
//   mode process : compare the point with every stored point, one memory read per
//                  cycle.
//   mode finish  : two iterative square roots of 17 steps each, then one item on
//                  the output channel; the roots are skipped when a set is empty.
//   Unused mode codes are taken and ignored.
// Throughput is set by the single read port of the point memory: one stored point
// per cycle during a scan, so a process item costs more the more points are stored
// (default capacity 256). The block works on one item at a time; in_ready is high only
// when no item is in progress.
// The output channel has its own register: store and process items are taken while
// a result waits; a finish holds in its last state until the slot is free.
// After reset (and after each finish) the point count, flags and running
// extremes are cleared; the point memory itself is not cleared.
module point_set_min_max_distance
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [psmmd_pkg::MODE_W-1:0]        mode,
    input  logic signed [psmmd_pkg::COORD_W-1:0] x_coord,
    input  logic signed [psmmd_pkg::COORD_W-1:0] y_coord,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psmmd_pkg::DIST_W-1:0]        min_distance,
    output logic [psmmd_pkg::DIST_W-1:0]        max_distance,
    output logic                                empty_flag,
    output logic                                overflow_flag
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    psmmd_pkg::state_t state_reg, state_next;

    logic                       in_accept;
    logic                       out_free;

    // set state
    logic [CW-1:0]              count_reg;
    logic                       seen_reg;
    logic                       dropped_reg;
    psmmd_pkg::sq_t             min_sq_reg;
    psmmd_pkg::sq_t             max_sq_reg;

    // point memory
    logic [psmmd_pkg::POINT_W-1:0] mem [MAX_POINTS];
    logic [psmmd_pkg::POINT_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic                       rd_en;

    // scan pipeline
    logic [CW-1:0]              issue_reg;
    logic signed [psmmd_pkg::COORD_W-1:0] qx_reg, qy_reg;
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [psmmd_pkg::DIFF_W-1:0]  dx_reg, dy_reg;
    psmmd_pkg::sq_t             dx2_reg, dy2_reg;
    psmmd_pkg::sq_t             sum_reg;
    logic signed [psmmd_pkg::COORD_W-1:0] px, py;
    logic signed [2*psmmd_pkg::DIFF_W-1:0] dx2_full, dy2_full;
    logic                       scan_done;

    // square root
    logic                       sq_start;
    psmmd_pkg::sq_t             sq_value;
    logic                       sq_done;
    psmmd_pkg::dist_t           sq_root;
    psmmd_pkg::dist_t           min_root_reg;
    psmmd_pkg::dist_t           max_root_reg;

    // output slot
    logic                       out_valid_reg;
    psmmd_pkg::dist_t           out_min_reg, out_max_reg;
    logic                       out_empty_reg, out_ovf_reg;
    logic                       set_empty;
    logic                       emit;

    assign in_ready  = (state_reg == psmmd_pkg::S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign set_empty = (count_reg == '0) || !seen_reg;
    assign emit      = (state_reg == psmmd_pkg::S_EMIT) && out_free;

    assign mem_we    = in_accept && (mode == psmmd_pkg::MODE_STORE)
                       && (count_reg < CW'(MAX_POINTS));
    assign rd_en     = (state_reg == psmmd_pkg::S_SCAN) && (issue_reg < count_reg);
    assign scan_done = (state_reg == psmmd_pkg::S_SCAN) && !rd_en
                       && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    // Start the root of the minimum on a finish with both sets present,
    // then the root of the maximum once the first is back.
    assign sq_start = (in_accept && (mode == psmmd_pkg::MODE_FINISH) && !set_empty)
                      || ((state_reg == psmmd_pkg::S_SQMIN) && sq_done);
    assign sq_value = (state_reg == psmmd_pkg::S_SQMIN) ? max_sq_reg : min_sq_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psmmd_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    case (mode)
                        psmmd_pkg::MODE_PROCESS:
                            if (count_reg != '0)
                                state_next = psmmd_pkg::S_SCAN;
                        psmmd_pkg::MODE_FINISH:
                            state_next = set_empty ? psmmd_pkg::S_EMIT
                                                   : psmmd_pkg::S_SQMIN;
                        default:
                            state_next = psmmd_pkg::S_IDLE;
                    endcase
                end
            end
            psmmd_pkg::S_SCAN:
                if (scan_done)
                    state_next = psmmd_pkg::S_IDLE;
            psmmd_pkg::S_SQMIN:
                if (sq_done)
                    state_next = psmmd_pkg::S_SQMAX;
            psmmd_pkg::S_SQMAX:
                if (sq_done)
                    state_next = psmmd_pkg::S_EMIT;
            psmmd_pkg::S_EMIT:
                if (out_free)
                    state_next = psmmd_pkg::S_IDLE;
            default:
                state_next = psmmd_pkg::S_IDLE;
        endcase
    end

    // control state and running extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psmmd_pkg::S_IDLE;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            min_sq_reg    <= psmmd_pkg::SQ_ALL_ONES;
            max_sq_reg    <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept && (mode == psmmd_pkg::MODE_STORE))
            begin
                if (mem_we)
                    count_reg <= count_reg + 1'b1;
                else
                    dropped_reg <= 1'b1;
            end

            // arm a scan: restart the read pointer, note the second set
            if (in_accept && (mode == psmmd_pkg::MODE_PROCESS) && (count_reg != '0))
            begin
                seen_reg  <= 1'b1;
                issue_reg <= '0;
            end
            else if (rd_en)
                issue_reg <= issue_reg + 1'b1;

            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (v4_reg)
            begin
                if (sum_reg < min_sq_reg)
                    min_sq_reg <= sum_reg;
                if (sum_reg > max_sq_reg)
                    max_sq_reg <= sum_reg;
            end

            // hand over the result and clear the set
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                seen_reg      <= 1'b0;
                dropped_reg   <= 1'b0;
                min_sq_reg    <= psmmd_pkg::SQ_ALL_ONES;
                max_sq_reg    <= '0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // point memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= {x_coord, y_coord};
        rd_data_reg <= mem[issue_reg[AW-1:0]];
    end

    assign px       = rd_data_reg[psmmd_pkg::POINT_W-1 -: psmmd_pkg::COORD_W];
    assign py       = rd_data_reg[psmmd_pkg::COORD_W-1:0];
    assign dx2_full = dx_reg * dx_reg;
    assign dy2_full = dy_reg * dy_reg;

    // distance pipeline: difference, square, sum
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            qx_reg <= x_coord;
            qy_reg <= y_coord;
        end
        dx_reg  <= psmmd_pkg::DIFF_W'(qx_reg) - psmmd_pkg::DIFF_W'(px);
        dy_reg  <= psmmd_pkg::DIFF_W'(qy_reg) - psmmd_pkg::DIFF_W'(py);
        dx2_reg <= psmmd_pkg::SQ_W'(dx2_full);
        dy2_reg <= psmmd_pkg::SQ_W'(dy2_full);
        sum_reg <= dx2_reg + dy2_reg;
    end

    psmmd_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == psmmd_pkg::S_SQMIN) && sq_done)
            min_root_reg <= sq_root;
        if ((state_reg == psmmd_pkg::S_SQMAX) && sq_done)
            max_root_reg <= sq_root;
        if (emit)
        begin
            out_min_reg   <= set_empty ? '0 : min_root_reg;
            out_max_reg   <= set_empty ? '0 : max_root_reg;
            out_empty_reg <= set_empty;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign min_distance  = out_min_reg;
    assign max_distance  = out_max_reg;
    assign empty_flag    = out_empty_reg;
    assign overflow_flag = out_ovf_reg;

endmodule

### sv/psmmd_sqrt.sv
// Iterative floor square root: one result bit per cycle.
module psmmd_sqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  psmmd_pkg::sq_t     value,
    output logic               done,
    output psmmd_pkg::dist_t   root
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [psmmd_pkg::SQRT_CNT_W-1:0]    step_reg;
    psmmd_pkg::sq_t                      val_reg;
    logic [psmmd_pkg::SQRT_REM_W-1:0]    rem_reg;
    psmmd_pkg::dist_t                    root_reg;

    logic [psmmd_pkg::SQRT_REM_W+1:0]    rem_shift;
    logic [psmmd_pkg::SQRT_REM_W+1:0]    trial;
    logic                                take;

    always_comb
    begin
        rem_shift = {rem_reg[psmmd_pkg::SQRT_REM_W-1:0],
                     val_reg[psmmd_pkg::SQ_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == psmmd_pkg::SQRT_CNT_W'(psmmd_pkg::SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
            end
            else
                done_reg <= 1'b0;
        end
    end

    // datapath: shift in two bits of the operand, try the next root bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[psmmd_pkg::SQ_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= psmmd_pkg::SQRT_REM_W'(rem_shift - trial);
                root_reg <= {root_reg[psmmd_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[psmmd_pkg::SQRT_REM_W-1:0];
                root_reg <= {root_reg[psmmd_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### tb/psmmd_checker.sv
// Checker for the point-set distance block: predicts each result and compares it.
module psmmd_checker
    import psmmd_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  mode_t                     mode,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  dist_t                     min_distance,
    input  dist_t                     max_distance,
    input  logic                      empty_flag,
    input  logic                      overflow_flag,
    output int                        mismatch_count,
    output int                        outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        dist_t nearest;
        dist_t farthest;
        logic  empty;
        logic  overflow;
    } distance_result_t;

    logic [POINT_W-1:0] stored_points [CAPACITY];
    int unsigned        stored_count;
    logic               scanned;
    sq_t                nearest_sq;
    sq_t                farthest_sq;
    logic               dropped;

    distance_result_t   awaited_distances [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic clear_sets();
        stored_count = 0;
        scanned      = 1'b0;
        nearest_sq   = SQ_ALL_ONES;
        farthest_sq  = '0;
        dropped      = 1'b0;
    endtask

    // Floor square root, built one result bit at a time from the top
    function automatic dist_t root_floor(input sq_t v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = DIST_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= longint'(v))
                r = t;
        end
        return dist_t'(r);
    endfunction

    task automatic track_extremes(input mode_t m, input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y);
        longint           dx;
        longint           dy;
        sq_t              sq;
        distance_result_t r;
        case (m)
            MODE_STORE:
            begin
                if (stored_count < CAPACITY)
                begin
                    stored_points[stored_count] = {x, y};
                    stored_count++;
                end
                else
                    dropped = 1'b1;
            end
            MODE_PROCESS:
            begin
                if (stored_count != 0)
                begin
                    scanned = 1'b1;
                    for (int i = 0; i < stored_count; i++)
                    begin
                        dx = longint'(x) - longint'($signed(stored_points[i][POINT_W-1:COORD_W]));
                        dy = longint'(y) - longint'($signed(stored_points[i][COORD_W-1:0]));
                        sq = sq_t'(dx * dx + dy * dy);
                        if (sq < nearest_sq)
                            nearest_sq = sq;
                        if (sq > farthest_sq)
                            farthest_sq = sq;
                    end
                end
            end
            MODE_FINISH:
            begin
                r.empty    = (stored_count == 0) || !scanned;
                r.nearest  = r.empty ? '0 : root_floor(nearest_sq);
                r.farthest = r.empty ? '0 : root_floor(farthest_sq);
                r.overflow = dropped;
                awaited_distances.push_back(r);
                clear_sets();
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        distance_result_t want;
        if (!rst_n)
        begin
            clear_sets();
            awaited_distances.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            // Retire the result first: one taken in this cycle belongs to an earlier finish
            if (out_valid && out_ready)
            begin
                if (awaited_distances.size() == 0)
                    report_mismatch("result with none awaited");
                else
                begin
                    want = awaited_distances.pop_front();
                    if (min_distance !== want.nearest)
                        report_mismatch($sformatf("min_distance %0d, predicted %0d",
                                                  min_distance, want.nearest));
                    if (max_distance !== want.farthest)
                        report_mismatch($sformatf("max_distance %0d, predicted %0d",
                                                  max_distance, want.farthest));
                    if (empty_flag !== want.empty)
                        report_mismatch($sformatf("empty_flag %b, predicted %b",
                                                  empty_flag, want.empty));
                    if (overflow_flag !== want.overflow)
                        report_mismatch($sformatf("overflow_flag %b, predicted %b",
                                                  overflow_flag, want.overflow));
                end
            end
            if (in_valid && in_ready)
                track_extremes(mode, x_coord, y_coord);
            outstanding = awaited_distances.size();
        end
    end

endmodule

### tb/tb_top.sv
// Top of the point-set distance testbench: clock, reset, stimulus and verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import psmmd_pkg::*;

    localparam int    CAPACITY     = 256;
    localparam int    ITEM_TARGET  = 1450;
    // Long enough for a full scan of CAPACITY points and a finish; allow for both
    localparam int    DRAIN_CYCLES = 400;
    // Nothing accepted for this long means the block has hung
    localparam int    STALL_LIMIT  = 5000;
    localparam mode_t MODE_UNUSED  = 2'd3;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    mode_t                     mode          = MODE_STORE;
    logic signed [COORD_W-1:0] x_coord       = '0;
    logic signed [COORD_W-1:0] y_coord       = '0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    dist_t                     min_distance;
    dist_t                     max_distance;
    logic                      empty_flag;
    logic                      overflow_flag;

    int mismatch_count;
    int outstanding;
    int quiet_cycles   = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    point_set_min_max_distance
    #(
        .MAX_POINTS(CAPACITY)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_distance (min_distance),
        .max_distance (max_distance),
        .empty_flag   (empty_flag),
        .overflow_flag(overflow_flag)
    );

    psmmd_checker
    #(
        .CAPACITY(CAPACITY)
    )
    i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .min_distance  (min_distance),
        .max_distance  (max_distance),
        .empty_flag    (empty_flag),
        .overflow_flag (overflow_flag),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hold reset once, at the start
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: stall at random per cycle, at the rate of the current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: give up when neither channel has moved an item for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Phases: 0 no idling, 1 sender mostly idle, 2 receiver mostly stalled, 3 both now and then
    task automatic set_phase(input int phase);
        case (phase)
            1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
            3:       begin send_idle_pct = 36; recv_stall_pct = 36; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one item and wait for it to be taken. Called at a rising edge; valid is
    // touched once per edge, so back-to-back items keep it high without a glitch.
    task automatic send_item(input mode_t m, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        x_coord  <= x;
        y_coord  <= y;
        // Ready read straight after the edge is the value the block saw at that edge
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // Mix full-range values, the field extremes and tight clusters so that
    // both far pairs and near or coincident pairs turn up
    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return COORD_W'($urandom);
        else if (pick < 7)
        begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        else
            return COORD_W'($urandom_range(0, 96)) - 16'd48;
    endfunction

    // Slip in an item with the unused mode code now and then; it must leave no trace
    task automatic maybe_noise();
        if ($urandom_range(24) == 0)
            send_item(MODE_UNUSED, rand_coord(), rand_coord());
    endtask

    // One measurement: first set, then second set (late first-set points mixed
    // in when asked), then finish. An early second-set point meets an empty store.
    task automatic run_session(input int n_store, input int n_proc,
                               input bit early_proc, input bit late_store);
        if (early_proc)
            repeat ($urandom_range(1, 2)) send_item(MODE_PROCESS, rand_coord(), rand_coord());
        repeat (n_store)
        begin
            maybe_noise();
            send_item(MODE_STORE, rand_coord(), rand_coord());
        end
        repeat (n_proc)
        begin
            maybe_noise();
            if (late_store && $urandom_range(3) == 0)
                send_item(MODE_STORE, rand_coord(), rand_coord());
            send_item(MODE_PROCESS, rand_coord(), rand_coord());
        end
        maybe_noise();
        send_item(MODE_FINISH, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    initial
    begin
        int session;
        int roll;
        int n_store;
        int n_proc;

        while (!rst_n)
            @(posedge clk);
        @(posedge clk);
        set_phase(0);

        // Finish on a fresh block: both sets empty
        send_item(MODE_FINISH, 16'h0000, 16'h0000);
        // Second-set point with nothing stored changes nothing
        send_item(MODE_PROCESS, 16'h0010, 16'h0020);
        send_item(MODE_FINISH, 16'h0000, 16'h0000);
        // First set alone still counts as empty
        send_item(MODE_STORE, 16'h7FFF, 16'h7FFF);
        send_item(MODE_FINISH, 16'h7FFF, 16'h7FFF);
        // Opposite corners for the largest distance, a coincident pair for zero
        send_item(MODE_STORE, 16'h8000, 16'h8000);
        send_item(MODE_STORE, 16'h7FFF, 16'h7FFF);
        send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
        send_item(MODE_PROCESS, 16'h7FFF, 16'h8000);
        send_item(MODE_PROCESS, 16'h8000, 16'h8000);
        // Late first-set point: seen only by the second-set point after it
        send_item(MODE_STORE, 16'h0000, 16'h0000);
        send_item(MODE_PROCESS, 16'hFFFF, 16'h0000);
        send_item(MODE_FINISH, 16'hFFFF, 16'hFFFF);

        // Random sessions; mostly small sets, a few that fill the store
        // and one forced past capacity so that points are dropped
        session = 0;
        while (items_sent < ITEM_TARGET)
        begin
            set_phase((session / 3) % 4);
            roll = $urandom_range(99);
            if (session == 10)
                n_store = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            else if (roll < 2)
                n_store = $urandom_range(CAPACITY - 6, CAPACITY + 6);
            else if (roll < 8)
                n_store = 0;
            else
                n_store = $urandom_range(1, 10);
            if (n_store > 32)
                n_proc = $urandom_range(1, 3);
            else if ($urandom_range(99) < 8)
                n_proc = 0;
            else
                n_proc = $urandom_range(1, 8);
            run_session(n_store, n_proc, $urandom_range(9) == 0, $urandom_range(4) == 0);
            session++;
        end
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
